[src/mini_risc_execute_unit_top_defines.svh]
// Assertion macros for the mini RISC execute unit.
// Used by mini_risc_execute_unit_top; expects i_clk and i_rst_n in scope.
`ifndef MINI_RISC_EXECUTE_UNIT_TOP_DEFINES_SVH
`define MINI_RISC_EXECUTE_UNIT_TOP_DEFINES_SVH

// ante implies cons at the same edge
`define MRE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond never holds
`define MRE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[src/mre_pkg.sv]
// Shared types and constants for the mini RISC execute unit.
// No dependencies; used by mre_data_mem and mini_risc_execute_unit_top.
package mre_pkg;

    // MEM_DEPTH must be a power of two (addresses wrap by truncation)
    localparam int MEM_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int DATA_W    = 8;
    localparam int REG_COUNT = 8;
    localparam int PC_W      = 9;

    localparam logic [2:0]      REG_GND    = 3'd0;
    localparam logic [2:0]      REG_SWITCH = 3'd7;
    localparam logic [PC_W-1:0] PC_STEP    = 9'd2;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_ADDI = 4'd4,
        OP_LW   = 4'd5,
        OP_SW   = 4'd6,
        OP_BEQ  = 4'd7,
        OP_J    = 4'd8
    } t_op;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] src_a;
        logic [2:0] src_b;
        logic [2:0] dest;
        logic [5:0] immediate;
        logic [7:0] switches;
    } t_in_word;

    typedef struct packed {
        logic       reg_write_enable;
        logic [2:0] reg_write_index;
        logic [7:0] reg_write_value;
        logic       store_enable;
        logic [7:0] store_address;
        logic [8:0] next_pc;
        logic       end_reached;
    } t_out_word;

    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_data wr_data;
    } t_dm_req;

endpackage

[src/mre_data_mem.sv]
// Data memory: synchronous RAM with per-entry valid bits (reads zero until
// written) and a bypass for a store landing on the same edge as the read. Uses mre_pkg.
module mre_data_mem (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mre_pkg::t_dm_req i_req,
    output mre_pkg::t_data   o_rd_data
);
    import mre_pkg::*;

    t_data                r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    t_data                r_rd_data;
    t_addr                r_rd_addr;
    logic                 r_rd_ok;
    logic                 r_byp_en;
    t_addr                r_byp_addr;
    t_data                r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_addr  <= i_req.rd_addr;
            r_byp_addr <= i_req.wr_addr;
            r_byp_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_ok  <= 1'b0;
            r_byp_en <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok  <= r_vld[i_req.rd_addr];
                r_byp_en <= i_req.wr_en;
            end
        end
    end

    always_comb begin
        if (r_byp_en && (r_byp_addr == r_rd_addr)) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

[src/mini_risc_execute_unit_top.sv]
// Mini RISC execute unit: register read, execute/address, memory/writeback.
// The input word is registered in r_s1, then r_s2, then r_out.
// Throughput: one word per cycle unless stalled; RF and data mem bypasses
// cover back-to-back dependencies, including load-use, without stalls.
// Reset: synchronous; it clears the register and memory valid bits.
`include "mini_risc_execute_unit_top_defines.svh"

module mini_risc_execute_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mre_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mre_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import mre_pkg::*;

    typedef struct packed {
        logic            wen;
        logic [2:0]      widx;
        t_data           value;
        logic            is_lw;
        logic            is_sw;
        logic            mem_op;
        t_addr           addr;
        t_data           sdata;
        logic [PC_W-1:0] pc;
    } t_s2_word;

    // pipeline control
    logic      r_s1_v, r_s2_v, r_out_v;
    logic      out_ready, en1, en2, retire;
    t_in_word  r_s1;
    t_s2_word  r_s2, n_s2;
    t_out_word r_out, n_out;
    logic [PC_W-1:0] r_pc, n_pc;

    // register file
    t_data          r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    t_data          r_rf_a, r_rf_b;
    logic           r_rf_a_ok, r_rf_b_ok;
    logic           r_lw_en;
    logic [2:0]     r_lw_idx;
    t_data          r_lw_val;

    t_dm_req        dm_req;
    t_data          dm_rd_data;
    t_data          w2, va, vb;
    logic [DATA_W:0] addr_sum;
    logic            wtry;
    logic [PC_W-1:0] pc_base;

    assign out_ready = !r_out_v || !i_out_stall;
    assign en2       = !r_s2_v || out_ready;
    assign en1       = !r_s1_v || en2;
    assign retire    = r_s2_v && out_ready;
    assign o_in_stall  = !en1;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    assign w2 = r_s2.is_lw ? dm_rd_data : r_s2.value;

    function automatic t_data rd_fwd(
        input logic [2:0] idx,
        input t_data      ram_val,
        input logic       ram_ok,
        input logic [7:0] sw,
        input logic       s2_hit,
        input t_data      s2_val,
        input logic       lw_hit,
        input t_data      lw_val
    );
        t_data v;
        if (idx == REG_GND) begin
            v = '0;
        end else if (idx == REG_SWITCH) begin
            v = t_data'(sw);
        end else if (s2_hit) begin
            v = s2_val;
        end else if (lw_hit) begin
            v = lw_val;
        end else if (ram_ok) begin
            v = ram_val;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    always_comb begin
        va = rd_fwd(r_s1.src_a, r_rf_a, r_rf_a_ok, r_s1.switches,
                    r_s2_v && r_s2.wen && (r_s2.widx == r_s1.src_a), w2,
                    r_lw_en && (r_lw_idx == r_s1.src_a), r_lw_val);
        vb = rd_fwd(r_s1.src_b, r_rf_b, r_rf_b_ok, r_s1.switches,
                    r_s2_v && r_s2.wen && (r_s2.widx == r_s1.src_b), w2,
                    r_lw_en && (r_lw_idx == r_s1.src_b), r_lw_val);
    end

    // execute / address stage
    always_comb begin
        n_s2     = '0;
        wtry     = 1'b0;
        pc_base  = r_pc;
        addr_sum = (DATA_W+1)'(va) + (DATA_W+1)'(r_s1.immediate);
        n_s2.addr  = t_addr'(addr_sum);
        n_s2.sdata = vb;
        case (t_op'(r_s1.mode))
            OP_ADD: begin
                n_s2.value = va + vb;
                n_s2.widx  = r_s1.dest;
                wtry       = 1'b1;
            end
            OP_SUB: begin
                n_s2.value = va - vb;
                n_s2.widx  = r_s1.dest;
                wtry       = 1'b1;
            end
            OP_AND: begin
                n_s2.value = va & vb;
                n_s2.widx  = r_s1.dest;
                wtry       = 1'b1;
            end
            OP_OR: begin
                n_s2.value = va | vb;
                n_s2.widx  = r_s1.dest;
                wtry       = 1'b1;
            end
            OP_ADDI: begin
                n_s2.value = va + t_data'(r_s1.immediate);
                n_s2.widx  = r_s1.src_b;
                wtry       = 1'b1;
            end
            OP_LW: begin
                n_s2.widx   = r_s1.src_b;
                n_s2.is_lw  = 1'b1;
                n_s2.mem_op = 1'b1;
                wtry        = 1'b1;
            end
            OP_SW: begin
                n_s2.is_sw  = 1'b1;
                n_s2.mem_op = 1'b1;
            end
            OP_BEQ: begin
                if (va == vb) begin
                    pc_base = r_pc + PC_W'({r_s1.immediate, 1'b0});
                end
            end
            OP_J: begin
                pc_base = PC_W'({r_s1.immediate, 1'b0});
            end
            default: begin
            end
        endcase
        n_s2.wen = wtry && (n_s2.widx != REG_GND) && (n_s2.widx != REG_SWITCH);
        n_pc     = pc_base + PC_STEP;
        n_s2.pc  = n_pc;
    end

    // result word
    always_comb begin
        n_out                  = '0;
        n_out.reg_write_enable = r_s2.wen;
        n_out.reg_write_index  = r_s2.wen ? r_s2.widx : 3'd0;
        n_out.reg_write_value  = r_s2.wen ? 8'(w2) : 8'd0;
        n_out.store_enable     = r_s2.is_sw;
        n_out.store_address    = r_s2.mem_op ? 8'(r_s2.addr) : 8'd0;
        n_out.next_pc          = r_s2.pc;
        n_out.end_reached      = 32'(r_s2.pc) >= 32'(MEM_DEPTH);
    end

    always_comb begin
        dm_req.rd_en   = en2;
        dm_req.rd_addr = n_s2.addr;
        dm_req.wr_en   = retire && r_s2.is_sw;
        dm_req.wr_addr = r_s2.addr;
        dm_req.wr_data = r_s2.sdata;
    end

    mre_data_mem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dm_req),
        .o_rd_data (dm_rd_data)
    );

    // register file RAM
    always_ff @(posedge i_clk) begin
        if (retire && r_s2.wen) begin
            r_rf[r_s2.widx] <= w2;
        end
        if (en1) begin
            r_rf_a   <= r_rf[i_in_word.src_a];
            r_rf_b   <= r_rf[i_in_word.src_b];
            r_lw_idx <= r_s2.widx;
            r_lw_val <= w2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_rf_a_ok <= 1'b0;
            r_rf_b_ok <= 1'b0;
            r_lw_en   <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_pc      <= '0;
        end else begin
            if (retire && r_s2.wen) begin
                r_rf_vld[r_s2.widx] <= 1'b1;
            end
            if (en1) begin
                r_rf_a_ok <= r_rf_vld[i_in_word.src_a];
                r_rf_b_ok <= r_rf_vld[i_in_word.src_b];
                r_lw_en   <= retire && r_s2.wen;
                r_s1_v    <= i_in_valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (out_ready) begin
                r_out_v <= r_s2_v;
            end
            if (r_s1_v && en2) begin
                r_pc <= n_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= i_in_word;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    `MRE_ASSERT_IMPL(a_stall_only_when_full, o_in_stall, r_s1_v && r_s2_v && r_out_v, "input stalled with a free stage")
    `MRE_ASSERT_IMPL(a_no_write_fixed_regs, o_out_valid && o_out_word.reg_write_enable, (o_out_word.reg_write_index != REG_GND) && (o_out_word.reg_write_index != REG_SWITCH), "write to fixed register")
    `MRE_ASSERT_NEVER(a_store_no_regwrite, r_s2_v && r_s2.is_sw && r_s2.wen, "store also writes a register")

endmodule

[tb/sv/mre_exec_checker.sv]
// Checker for mini_risc_execute_unit_top: watches both channels, predicts
// each result word from its own copy of registers, memory and PC, and compares.
// Depends on mre_pkg for the word types, opcodes and sizes.
module mre_exec_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mre_pkg::t_in_word  i_in_word,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  mre_pkg::t_out_word i_out_word,
    input  logic               i_out_stall,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mre_pkg::*;

    t_data           reg_shadow [REG_COUNT];
    t_data           mem_shadow [MEM_DEPTH];
    logic [PC_W-1:0] pc_shadow;
    t_out_word       expected_words [$];
    t_out_word       oldest_word;
    int              mismatch_total;
    bit              word_bad;

    function automatic t_data read_reg(logic [2:0] idx, logic [7:0] sw);
        if (idx == REG_SWITCH) begin
            return sw;
        end
        if (idx == REG_GND) begin
            return '0;
        end
        return reg_shadow[idx];
    endfunction

    task automatic execute_word(input t_in_word w);
        t_data           va;
        t_data           vb;
        t_data           wval;
        logic [2:0]      widx;
        bit              wtry;
        int              ea;
        logic [PC_W-1:0] pc;
        t_out_word       r;
        va   = read_reg(w.src_a, w.switches);
        vb   = read_reg(w.src_b, w.switches);
        wval = '0;
        widx = '0;
        wtry = 1'b0;
        ea   = (int'(va) + int'(w.immediate)) % MEM_DEPTH;
        pc   = pc_shadow;
        r    = '0;
        case (w.mode)
            OP_ADD: begin
                wval = va + vb;
                widx = w.dest;
                wtry = 1'b1;
            end
            OP_SUB: begin
                wval = va - vb;
                widx = w.dest;
                wtry = 1'b1;
            end
            OP_AND: begin
                wval = va & vb;
                widx = w.dest;
                wtry = 1'b1;
            end
            OP_OR: begin
                wval = va | vb;
                widx = w.dest;
                wtry = 1'b1;
            end
            OP_ADDI: begin
                wval = va + w.immediate;
                widx = w.src_b;
                wtry = 1'b1;
            end
            OP_LW: begin
                wval = mem_shadow[ea];
                widx = w.src_b;
                wtry = 1'b1;
                r.store_address = ea[7:0];
            end
            OP_SW: begin
                mem_shadow[ea]  = vb;
                r.store_enable  = 1'b1;
                r.store_address = ea[7:0];
            end
            OP_BEQ: begin
                if (va == vb) begin
                    pc = pc + {w.immediate, 1'b0};
                end
            end
            OP_J: begin
                pc = {w.immediate, 1'b0};
            end
            default: ;
        endcase
        if (wtry && widx != REG_GND && widx != REG_SWITCH) begin
            reg_shadow[widx]  = wval;
            r.reg_write_enable = 1'b1;
            r.reg_write_index  = widx;
            r.reg_write_value  = wval;
        end
        pc            = pc + PC_STEP;
        pc_shadow     = pc;
        r.next_pc     = pc;
        r.end_reached = (pc >= MEM_DEPTH);
        expected_words.push_back(r);
    endtask

    function automatic bit field_ok(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (reg_shadow[k]) reg_shadow[k] = '0;
            foreach (mem_shadow[k]) mem_shadow[k] = '0;
            pc_shadow      = '0;
            mismatch_total = 0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %p", i_out_word);
                    mismatch_total++;
                end else begin
                    oldest_word = expected_words.pop_front();
                    word_bad = 1'b0;
                    word_bad |= !field_ok("reg_write_enable",
                        oldest_word.reg_write_enable, i_out_word.reg_write_enable);
                    word_bad |= !field_ok("reg_write_index",
                        oldest_word.reg_write_index, i_out_word.reg_write_index);
                    word_bad |= !field_ok("reg_write_value",
                        oldest_word.reg_write_value, i_out_word.reg_write_value);
                    word_bad |= !field_ok("store_enable",
                        oldest_word.store_enable, i_out_word.store_enable);
                    word_bad |= !field_ok("store_address",
                        oldest_word.store_address, i_out_word.store_address);
                    word_bad |= !field_ok("next_pc",
                        oldest_word.next_pc, i_out_word.next_pc);
                    word_bad |= !field_ok("end_reached",
                        oldest_word.end_reached, i_out_word.end_reached);
                    if (word_bad) begin
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                execute_word(i_in_word);
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= expected_words.size();
    end

endmodule

[tb/sv/mini_risc_execute_unit_top_tb.sv]
// Testbench top for mini_risc_execute_unit_top: directed and random instruction
// words with random idling on both channels; verdict from mre_exec_checker.
// Depends on mre_pkg, mre_exec_checker and the RTL.
module mini_risc_execute_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mre_pkg::*;

    localparam logic [3:0] OP_NOP_FIRST = 4'd9;
    localparam logic [3:0] OP_NOP_LAST  = 4'd15;
    localparam int         OP_TARGET    = 850;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    t_in_word  in_word;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall;
    int        fail_count;
    int        pending;
    bit        no_idle;

    mini_risc_execute_unit_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    mre_exec_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_word    (in_word),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_word   (out_word),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    function automatic t_in_word make_word(logic [3:0] mode, logic [2:0] a, logic [2:0] b,
                                           logic [2:0] d, logic [5:0] imm, logic [7:0] sw);
        t_in_word w;
        w.mode      = mode;
        w.src_a     = a;
        w.src_b     = b;
        w.dest      = d;
        w.immediate = imm;
        w.switches  = sw;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 13));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // result side: random stall before each word unless no_idle is set
    initial begin
        int n;
        out_stall = 1'b0;
        wait (rst_n);
        forever begin
            n = no_idle ? 0 : int'($urandom_range(0, 13));
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        #1000000;
        $display("[mini_risc_execute_unit_top] ERROR");
        $finish;
    end

    initial begin
        int       ops_sent;
        int       phase;
        int       pick;
        t_in_word w;
        clk      = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        no_idle  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_word(make_word(OP_ADDI, 3'd0, 3'd1, 3'd0, 6'd63, 8'd0));
        send_word(make_word(OP_ADDI, 3'd7, 3'd2, 3'd0, 6'd63, 8'd255));
        send_word(make_word(OP_ADD,  3'd1, 3'd7, 3'd3, 6'd0,  8'd200));
        send_word(make_word(OP_SUB,  3'd0, 3'd7, 3'd4, 6'd0,  8'd255));
        send_word(make_word(OP_AND,  3'd1, 3'd2, 3'd5, 6'd0,  8'd0));
        send_word(make_word(OP_OR,   3'd3, 3'd7, 3'd6, 6'd0,  8'h5a));
        send_word(make_word(OP_ADD,  3'd1, 3'd2, 3'd0, 6'd0,  8'd0));
        send_word(make_word(OP_ADD,  3'd1, 3'd2, 3'd7, 6'd0,  8'd0));
        send_word(make_word(OP_ADDI, 3'd1, 3'd7, 3'd0, 6'd5,  8'd0));
        send_word(make_word(OP_SW,   3'd7, 3'd1, 3'd0, 6'd63, 8'd255));
        send_word(make_word(OP_LW,   3'd2, 3'd6, 3'd0, 6'd0,  8'd0));
        send_word(make_word(OP_LW,   3'd0, 3'd5, 3'd0, 6'd0,  8'd0));
        send_word(make_word(OP_SW,   3'd0, 3'd7, 3'd0, 6'd10, 8'ha5));
        send_word(make_word(OP_LW,   3'd0, 3'd4, 3'd0, 6'd10, 8'd0));
        send_word(make_word(OP_LW,   3'd0, 3'd7, 3'd0, 6'd10, 8'd0));
        send_word(make_word(OP_BEQ,  3'd0, 3'd0, 3'd0, 6'd63, 8'd0));
        send_word(make_word(OP_BEQ,  3'd1, 3'd0, 3'd0, 6'd63, 8'd0));
        send_word(make_word(OP_J,    3'd0, 3'd0, 3'd0, 6'd63, 8'd0));
        repeat (4) send_word(make_word(OP_BEQ, 3'd7, 3'd7, 3'd0, 6'd63, 8'd0));
        send_word(make_word(OP_J,    3'd0, 3'd0, 3'd0, 6'd0,  8'd0));
        send_word(make_word(OP_NOP_FIRST, 3'd7, 3'd7, 3'd7, 6'd63, 8'd255));
        send_word(make_word(OP_NOP_LAST,  3'd0, 3'd0, 3'd0, 6'd0,  8'd0));
        wait_drained();

        ops_sent = 0;
        phase    = 0;
        while (ops_sent < OP_TARGET) begin
            pick        = int'($urandom_range(0, 99));
            w.src_a     = 3'($urandom_range(0, 7));
            w.src_b     = 3'($urandom_range(0, 7));
            w.dest      = 3'($urandom_range(0, 7));
            w.immediate = 6'($urandom_range(0, 63));
            w.switches  = 8'($urandom_range(0, 255));
            if (pick < 8) begin
                w.mode = 4'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
            end else begin
                w.mode = 4'($urandom_range(OP_ADD, OP_J));
            end
            ops_sent++;
            // keep loads and stores with odd pick on addresses 0 to 7 so they meet
            if ((w.mode == OP_LW || w.mode == OP_SW) && pick[0]) begin
                w.src_a     = REG_GND;
                w.immediate = 6'($urandom_range(0, 7));
            end
            send_word(w);
            if (ops_sent % 100 == 0) begin
                phase++;
                no_idle = (phase % 3 == 1);
                if (phase % 2 == 0) begin
                    wait_drained();
                end
            end
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("[mini_risc_execute_unit_top] OK");
        end else begin
            $display("[mini_risc_execute_unit_top] ERROR");
        end
        $finish;
    end

endmodule
